>>> design/plenv_pkg.sv
// Shared types and constants for the piecewise-linear envelope gain stage.
// Has no dependencies; every other design file imports it.
`default_nettype none

package plenv_pkg;

	// Register indexes of the configuration port.
	typedef enum logic [2:0] {
		REG_START_LEVEL   = 3'd0,
		REG_SEGMENT_COUNT = 3'd1,
		REG_LEVEL_ONE     = 3'd2,
		REG_LEVEL_TWO     = 3'd3,
		REG_LEVEL_THREE   = 3'd4,
		REG_LENGTH_ONE    = 3'd5,
		REG_LENGTH_TWO    = 3'd6,
		REG_LENGTH_THREE  = 3'd7
	} reg_idx_t;

	// Reset value of every level register: unity gain in Q2.14.
	localparam logic signed [15:0] LEVEL_RESET = 16'sd16384;

	// Segment end positions are sums of up to three 16-bit lengths.
	localparam int BOUND_W = 18;

	// The divider retires four quotient bits in each of four stages.
	localparam int DIV_BITS = 4;

	// Pipeline depth, from the input register to the output register.
	localparam int STAGES = 10;

	// Values that ride alongside the divider.
	typedef struct packed {
		logic signed [15:0] prev;
		logic               neg;
		logic signed [15:0] sample;
	} side_t;

endpackage

`default_nettype wire

>>> design/plenv_cfg.sv
// Configuration register file and segment end positions.
// Depends on plenv_pkg.
`default_nettype none

module plenv_cfg
	import plenv_pkg::*;
#(
	parameter int MAX_SEGMENTS = 3
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      wr_en,
	input  wire logic [2:0]                wr_index,
	input  wire logic [15:0]               wr_data,
	output logic signed [15:0]             start_level,
	output logic [1:0]                     count,
	output logic signed [15:0]             level [MAX_SEGMENTS],
	output logic [15:0]                    len   [MAX_SEGMENTS],
	output logic [BOUND_W-1:0]             bound [MAX_SEGMENTS]
);

	logic signed [15:0]  start_q;
	logic [1:0]          count_q;
	logic signed [15:0]  level_q [MAX_SEGMENTS];
	logic [15:0]         len_q   [MAX_SEGMENTS];
	logic [BOUND_W-1:0]  bound_q [MAX_SEGMENTS];
	logic [BOUND_W-1:0]  cum     [MAX_SEGMENTS];

	// Register writes; indexes of segments not built are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= LEVEL_RESET;
			count_q <= 2'd0;
			for (int k = 0; k < MAX_SEGMENTS; k++) begin
				level_q[k] <= LEVEL_RESET;
				len_q[k]   <= 16'd0;
			end
		end else if (wr_en) begin
			case (reg_idx_t'(wr_index))
				REG_START_LEVEL:   start_q <= wr_data;
				REG_SEGMENT_COUNT: count_q <= wr_data[1:0];
				default: ;
			endcase
			for (int k = 0; k < MAX_SEGMENTS; k++) begin
				if (wr_index == 3'(REG_LEVEL_ONE) + 3'(k))
					level_q[k] <= wr_data;
				if (wr_index == 3'(REG_LENGTH_ONE) + 3'(k))
					len_q[k] <= wr_data;
			end
		end
	end

	// Running sum of the lengths gives the frame at which each segment ends.
	always_comb begin
		logic [BOUND_W-1:0] acc;
		acc = '0;
		for (int k = 0; k < MAX_SEGMENTS; k++) begin
			acc    = acc + BOUND_W'(len_q[k]);
			cum[k] = acc;
		end
	end

	// The end positions are registered; an item in stage 1 is compared against them.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_SEGMENTS; k++)
				bound_q[k] <= '0;
		end else begin
			for (int k = 0; k < MAX_SEGMENTS; k++)
				bound_q[k] <= cum[k];
		end
	end

	// Counts above the segments built are treated as all of them.
	assign count       = (count_q > 2'(MAX_SEGMENTS)) ? 2'(MAX_SEGMENTS) : count_q;
	assign start_level = start_q;
	assign level       = level_q;
	assign len         = len_q;
	assign bound       = bound_q;

endmodule

`default_nettype wire

>>> design/plenv_seg.sv
// Segment lookup and the offset-times-difference product (stages 2 and 3).
// Depends on plenv_pkg.
`default_nettype none

module plenv_seg
	import plenv_pkg::*;
#(
	parameter int MAX_SEGMENTS = 3
) (
	input  wire logic                 clk,
	input  wire logic                 en_s2,
	input  wire logic                 en_s3,
	input  wire logic [15:0]          frame_s1,
	input  wire logic signed [15:0]   sample_s1,
	input  wire logic signed [15:0]   start_level,
	input  wire logic [1:0]           count,
	input  wire logic signed [15:0]   level [MAX_SEGMENTS],
	input  wire logic [15:0]          len   [MAX_SEGMENTS],
	input  wire logic [BOUND_W-1:0]   bound [MAX_SEGMENTS],
	output logic [31:0]               mag_s3,
	output logic [15:0]               len_s3,
	output side_t                     side_s3
);

	logic                 found;
	logic signed [15:0]   sel_prev;
	logic signed [15:0]   sel_next;
	logic [BOUND_W-1:0]   sel_start;
	logic [15:0]          sel_len;
	logic [BOUND_W-1:0]   off_full;

	logic [15:0]          off_s2;
	logic signed [16:0]   diff_s2;
	logic [15:0]          len_s2;
	logic signed [15:0]   prev_s2;
	logic signed [15:0]   sample_s2;
	logic [15:0]          absd;

	// Find the first segment in use that has not ended by this frame. Past the
	// last one the level holds, which is an empty interpolation over one frame.
	always_comb begin
		logic signed [15:0]  prev_run;
		logic [BOUND_W-1:0]  start_run;
		prev_run  = start_level;
		start_run = '0;
		found     = 1'b0;
		sel_prev  = start_level;
		sel_next  = start_level;
		sel_start = '0;
		sel_len   = 16'd1;
		for (int k = 0; k < MAX_SEGMENTS; k++) begin
			if (2'(k) < count) begin
				if (!found && (BOUND_W'(frame_s1) < bound[k])) begin
					found     = 1'b1;
					sel_prev  = prev_run;
					sel_next  = level[k];
					sel_start = start_run;
					sel_len   = len[k];
				end
				prev_run  = level[k];
				start_run = bound[k];
			end
		end
		if (!found) begin
			sel_prev  = prev_run;
			sel_next  = prev_run;
			sel_start = BOUND_W'(frame_s1);
		end
	end

	// The offset is below the segment length, so it fits in 16 bits.
	assign off_full = BOUND_W'(frame_s1) - sel_start;

	// Stage 2: offset, level difference and segment length.
	always_ff @(posedge clk) begin
		if (en_s2) begin
			off_s2    <= off_full[15:0];
			diff_s2   <= 17'(sel_next) - 17'(sel_prev);
			len_s2    <= sel_len;
			prev_s2   <= sel_prev;
			sample_s2 <= sample_s1;
		end
	end

	// The magnitude of a 16-bit difference never exceeds 65535.
	always_comb begin
		logic [16:0] neg_d;
		neg_d = 17'(-diff_s2);
		absd  = diff_s2[16] ? neg_d[15:0] : diff_s2[15:0];
	end

	// Stage 3: unsigned product of offset and difference magnitude.
	always_ff @(posedge clk) begin
		if (en_s3) begin
			mag_s3         <= off_s2 * absd;
			len_s3         <= len_s2;
			side_s3.prev   <= prev_s2;
			side_s3.neg    <= diff_s2[16];
			side_s3.sample <= sample_s2;
		end
	end

endmodule

`default_nettype wire

>>> design/plenv_div.sv
// Pipelined restoring divider, four quotient bits per stage (stages 4 to 7).
// Depends on plenv_pkg.
`default_nettype none

module plenv_div
	import plenv_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         en_s4,
	input  wire logic         en_s5,
	input  wire logic         en_s6,
	input  wire logic         en_s7,
	input  wire logic [31:0]  mag_s3,
	input  wire logic [15:0]  len_s3,
	input  wire side_t        side_s3,
	output logic [15:0]       quot_s7,
	output side_t             side_s7
);

	// The word holds the partial remainder above and the dividend bits still to
	// be used, with quotient bits shifted in from below. The remainder is always
	// below the divisor, which holds because the quotient fits in 16 bits.
	function automatic logic [31:0] div_chunk(input logic [31:0] a, input logic [15:0] d);
		logic [32:0] sh;
		logic [16:0] top;
		logic [31:0] w;
		w = a;
		for (int i = 0; i < DIV_BITS; i++) begin
			sh  = {w, 1'b0};
			top = sh[32:16];
			if (top >= {1'b0, d}) begin
				top   = top - {1'b0, d};
				sh[0] = 1'b1;
			end
			w = {top[15:0], sh[15:0]};
		end
		return w;
	endfunction

	logic [31:0] acc_s4, acc_s5, acc_s6, acc_s7;
	logic [15:0] len_s4, len_s5, len_s6;
	side_t       side_s4, side_s5, side_s6;

	// Four divider stages; the divisor and side values travel with the word.
	always_ff @(posedge clk) begin
		if (en_s4) begin
			acc_s4  <= div_chunk(mag_s3, len_s3);
			len_s4  <= len_s3;
			side_s4 <= side_s3;
		end
		if (en_s5) begin
			acc_s5  <= div_chunk(acc_s4, len_s4);
			len_s5  <= len_s4;
			side_s5 <= side_s4;
		end
		if (en_s6) begin
			acc_s6  <= div_chunk(acc_s5, len_s5);
			len_s6  <= len_s5;
			side_s6 <= side_s5;
		end
		if (en_s7) begin
			acc_s7  <= div_chunk(acc_s6, len_s6);
			side_s7 <= side_s6;
		end
	end

	assign quot_s7 = acc_s7[15:0];

endmodule

`default_nettype wire

>>> design/plenv_gain.sv
// Level reconstruction, sample multiply and saturation (stages 8 to 10).
// Depends on plenv_pkg.
`default_nettype none

module plenv_gain
	import plenv_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                en_s8,
	input  wire logic                en_s9,
	input  wire logic                en_s10,
	input  wire logic [15:0]         quot_s7,
	input  wire side_t               side_s7,
	output logic signed [15:0]       scaled_sample,
	output logic signed [15:0]       envelope_level
);

	logic signed [17:0] step;
	logic signed [17:0] level_sum;
	logic signed [15:0] level_s8, level_s9, level_s10;
	logic signed [15:0] sample_s8;
	logic signed [31:0] prod_s9;
	logic signed [17:0] shifted;
	logic signed [15:0] sat;
	logic signed [15:0] scaled_s10;

	// The quotient magnitude takes the sign of the difference, which is the
	// same as truncating the signed quotient toward zero.
	assign step      = side_s7.neg ? -$signed({2'b00, quot_s7}) : $signed({2'b00, quot_s7});
	assign level_sum = 18'(side_s7.prev) + step;

	// Stage 8: the level lies between two 16-bit levels, so it fits.
	always_ff @(posedge clk) begin
		if (en_s8) begin
			level_s8  <= level_sum[15:0];
			sample_s8 <= side_s7.sample;
		end
	end

	// Stage 9: signed product of sample and level.
	always_ff @(posedge clk) begin
		if (en_s9) begin
			prod_s9  <= sample_s8 * level_s8;
			level_s9 <= level_s8;
		end
	end

	// Arithmetic shift by 14 rounds toward minus infinity; then clamp.
	assign shifted = prod_s9[31:14];
	always_comb begin
		if (shifted > 18'sd32767)
			sat = 16'sh7FFF;
		else if (shifted < -18'sd32768)
			sat = 16'sh8000;
		else
			sat = shifted[15:0];
	end

	// Stage 10: output register.
	always_ff @(posedge clk) begin
		if (en_s10) begin
			scaled_s10 <= sat;
			level_s10  <= level_s9;
		end
	end

	assign scaled_sample  = scaled_s10;
	assign envelope_level = level_s10;

endmodule

`default_nettype wire

>>> design/piecewise_linear_envelope_vca.sv
// Piecewise-linear envelope gain stage: top level with pipeline control.
// Depends on plenv_pkg, plenv_cfg, plenv_seg, plenv_div and plenv_gain.
//
// Each input item is a sample with its absolute frame number; each result
// item is the sample scaled by the envelope level for that frame, together
// with the level itself. Input and result channels use valid and stall: an
// item moves on an edge with valid high and stall low.
// Configuration writes arrive on their own valid/ready channel with a
// register index and 16 data bits; ready is always high. Write only while no
// item is in flight.
// The pipeline has ten register stages; a result is valid once its item has
// passed through all of them and reached the output register. One item
// is taken every cycle unless a stall holds the pipeline; the depth comes
// mostly from the interpolation divider, four stages of four quotient bits each.
// Every stage has its own valid bit and moves on when the stage after it is
// empty or moving, so a stalled receiver fills the empty stages first and
// only then stalls the source; no item is lost or repeated.
// Reset clears the valid bits and sets the registers to unity start level,
// no segments and zero lengths; the block takes items from the first cycle.
`default_nettype none

module piecewise_linear_envelope_vca
	import plenv_pkg::*;
#(
	parameter int ENVELOPE_FRAMES = 65536,
	parameter int MAX_SEGMENTS    = 3
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                frame_valid,
	output logic                     frame_stall,
	input  wire logic [15:0]         frame_index,
	input  wire logic signed [15:0]  sample,
	output logic                     result_valid,
	input  wire logic                result_stall,
	output logic signed [15:0]       scaled_sample,
	output logic signed [15:0]       envelope_level,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [2:0]          cfg_index,
	input  wire logic [15:0]         cfg_data
);

	localparam logic [31:0] FRAME_LAST = 32'(ENVELOPE_FRAMES - 1);

	logic [STAGES:1]     stage_valid_q;
	logic [STAGES+1:1]   en;

	logic signed [15:0]  start_level;
	logic [1:0]          count;
	logic signed [15:0]  level [MAX_SEGMENTS];
	logic [15:0]         len   [MAX_SEGMENTS];
	logic [BOUND_W-1:0]  bound [MAX_SEGMENTS];

	logic [15:0]         frame_s1;
	logic signed [15:0]  sample_s1;
	logic [31:0]         mag_s3;
	logic [15:0]         len_s3;
	side_t               side_s3;
	logic [15:0]         quot_s7;
	side_t               side_s7;

	assign cfg_ready = 1'b1;

	// A stage may load when it is empty or its contents move on.
	always_comb begin
		en[STAGES+1] = !result_stall;
		for (int k = STAGES; k >= 1; k--)
			en[k] = !stage_valid_q[k] || en[k+1];
	end

	assign frame_stall  = !en[1];
	assign result_valid = stage_valid_q[STAGES];

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_valid_q <= '0;
		end else begin
			if (en[1])
				stage_valid_q[1] <= frame_valid;
			for (int k = 2; k <= STAGES; k++)
				if (en[k])
					stage_valid_q[k] <= stage_valid_q[k-1];
		end
	end

	// Stage 1: input register; frames past the envelope read as its last frame.
	always_ff @(posedge clk) begin
		if (en[1]) begin
			frame_s1  <= (32'(frame_index) > FRAME_LAST) ? FRAME_LAST[15:0] : frame_index;
			sample_s1 <= sample;
		end
	end

	plenv_cfg #(
		.MAX_SEGMENTS (MAX_SEGMENTS)
	) u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr_en       (cfg_valid && cfg_ready),
		.wr_index    (cfg_index),
		.wr_data     (cfg_data),
		.start_level (start_level),
		.count       (count),
		.level       (level),
		.len         (len),
		.bound       (bound)
	);

	plenv_seg #(
		.MAX_SEGMENTS (MAX_SEGMENTS)
	) u_seg (
		.clk         (clk),
		.en_s2       (en[2]),
		.en_s3       (en[3]),
		.frame_s1    (frame_s1),
		.sample_s1   (sample_s1),
		.start_level (start_level),
		.count       (count),
		.level       (level),
		.len         (len),
		.bound       (bound),
		.mag_s3      (mag_s3),
		.len_s3      (len_s3),
		.side_s3     (side_s3)
	);

	plenv_div u_div (
		.clk     (clk),
		.en_s4   (en[4]),
		.en_s5   (en[5]),
		.en_s6   (en[6]),
		.en_s7   (en[7]),
		.mag_s3  (mag_s3),
		.len_s3  (len_s3),
		.side_s3 (side_s3),
		.quot_s7 (quot_s7),
		.side_s7 (side_s7)
	);

	plenv_gain u_gain (
		.clk            (clk),
		.en_s8          (en[8]),
		.en_s9          (en[9]),
		.en_s10         (en[10]),
		.quot_s7        (quot_s7),
		.side_s7        (side_s7),
		.scaled_sample  (scaled_sample),
		.envelope_level (envelope_level)
	);

	// A result leaving frees the whole pipeline, so the source is never stalled.
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_stall) |-> !frame_stall)
		else $error("source stalled while a result was leaving");

	// An empty pipeline always takes an item.
	assert property (@(posedge clk) disable iff (!arst_n)
		(stage_valid_q == '0) |-> !frame_stall)
		else $error("empty pipeline stalled the source");

	// A result only appears when the stage before held an item.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(stage_valid_q[STAGES-1]))
		else $error("result appeared from an empty stage");

	// While the receiver stalls, the number of items in flight cannot fall.
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_stall && result_valid) |=>
			($countones(stage_valid_q) >= $past($countones(stage_valid_q))))
		else $error("item lost in the pipeline during a stall");

endmodule

`default_nettype wire
